FILE: design/dbts_pkg.sv
package dbts_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int DEPTH_BITS = 24;

   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DIM_W      = 16;
   localparam int CFG_W      = 10;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = {DEPTH_BITS{1'b1}};

   localparam logic [CFG_W-1:0] MAP_WIDTH_RESET  = CFG_W'(512);
   localparam logic [CFG_W-1:0] MAP_HEIGHT_RESET = CFG_W'(512);

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   localparam logic [1:0] FUNC_TEST   = 2'd0;
   localparam logic [1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_CMP,
      ST_DONE
   } dbts_state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] col;
      logic signed [15:0] row;
      logic [23:0]        new_depth;
   } req_type;

   typedef struct packed {
      logic        written;
      logic [23:0] depth_out;
   } rsp_type;

endpackage

FILE: design/depth_buffer_test_and_sample_top.sv
// channel | direction | handshake             | beat
// req     | in        | req_valid / req_stall | req_type: func, col, row, new_depth
// rsp     | out       | rsp_valid / rsp_stall | rsp_type: written, depth_out
// csr     | in/out    | APB psel/penable      | map_width at 0x0, map_height at 0x4
//
// Test and sample step through accept, address multiply, store read, compare
// and write back through the single store port, req_stall high after accept.
// Clear and reset each sweep all STORE_SIZE (262144) entries of the store one
// entry per cycle, with req_stall high; a clear answers after its sweep.
// A finished result waits in the output register while the next beat proceeds;
// a beat only reaches the compare step once that register is free.
module depth_buffer_test_and_sample_top
   import dbts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   dbts_state_type state_ff, state_in;

   logic [CFG_W-1:0]      width_ff, height_ff;
   logic [1:0]            func_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic                  hit_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [DIM_W-1:0]      weff, heff;
   logic                  in_range;
   logic                  accept;
   logic                  out_free;
   logic                  load_rsp;
   rsp_type               rsp_next;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [DEPTH_BITS-1:0] ram_wdata, ram_rdata;

   assign weff = (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_ff);
   assign heff = (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : DIM_W'(height_ff);

   assign in_range = !req_data.col[15] && !req_data.row[15] &&
                     (DIM_W'(unsigned'(req_data.col)) < weff) &&
                     (DIM_W'(unsigned'(req_data.row)) < heff);

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // configuration
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAP_WIDTH_RESET;
         height_ff <= MAP_HEIGHT_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[2])
            REG_MAP_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_MAP_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAP_WIDTH:  prdata = PDATA_W'(width_ff);
         REG_MAP_HEIGHT: prdata = PDATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         clr_rsp_ff <= clr_rsp_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_data.func;
         col_ff   <= req_data.col[COL_W-1:0];
         row_ff   <= req_data.row[ROW_W-1:0];
         depth_ff <= DEPTH_BITS'(req_data.new_depth);
         hit_ff   <= in_range;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(weff)) + ADDR_W'(col_ff);
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      req_stall  = 1'b1;
      ram_we     = 1'b0;
      ram_addr   = addr_ff;
      ram_wdata  = depth_ff;
      load_rsp   = 1'b0;
      rsp_next   = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_ff;
            ram_wdata = DEPTH_FAR;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(STORE_SIZE - 1)) begin
               sweep_in = '0;
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.func == FUNC_CLEAR) begin
                  state_in   = ST_CLEAR;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (out_free) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            load_rsp = 1'b1;
            case (func_ff)
               FUNC_TEST: begin
                  if (hit_ff && (depth_ff < ram_rdata)) begin
                     ram_we           = 1'b1;
                     rsp_next.written = 1'b1;
                  end
               end
               FUNC_SAMPLE: begin
                  rsp_next.depth_out = hit_ff ? 24'(ram_rdata) : 24'(DEPTH_FAR);
               end
               default: ;
            endcase
            state_in = ST_IDLE;
         end
         ST_DONE: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               clr_rsp_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   dbts_ram #(
      .WIDTH (DEPTH_BITS),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/dbts_ram.sv
module dbts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
